// ===== hdl/pbf_pkg.sv =====
// Package for the parenthesis balance filter: constants, item types and FSM states.
package pbf_pkg;

  localparam int unsigned MaxLen = 64;

  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChZ     = 8'h7a;
  localparam logic [7:0] ChOpen  = 8'h28;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } pbf_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       keep;
    logic       last_out;
    logic       overflow;
  } pbf_out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_UNWIND,
    ST_DRAIN
  } pbf_state_e;

endpackage

// ===== hdl/paren_balance_filter.sv =====
// With '(' left open at the final byte, the stack is popped once per open entry and the
// keep bit of each popped entry is written back as cleared; the unwind then passes one idle
// step before the first stored byte is read. With none left open the unwind is skipped. Results
// then leave at one per cycle while out_ready_i is high. Throughput: one byte per cycle while
// loading; input is held off from the final byte until the last stored byte is read.
// Reset: asynchronous, active low; counters, stack depth and FSM clear, memories do not.
module paren_balance_filter #(
  parameter int unsigned MAX_LEN = pbf_pkg::MaxLen
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbf_pkg::pbf_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbf_pkg::pbf_out_t out_o
);
  import pbf_pkg::*;

  localparam int unsigned IW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] LenC = CW'(MAX_LEN);

  pbf_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          ovf_q, ovf_d;
  logic          pop_vld_q, pop_vld_d;
  logic          out_vld_q, out_vld_d;

  logic [7:0]    byte_mem [MAX_LEN];
  logic          keep_mem [MAX_LEN];
  logic [IW-1:0] stk_mem  [MAX_LEN];

  logic [7:0]    byte_rd_q;
  logic          keep_rd_q;
  logic [IW-1:0] stk_rd_q;
  logic          last_q;
  logic          oflag_q;

  logic          acc;
  logic          is_letter;
  logic          is_open;
  logic          byte_we;
  logic          keep_we;
  logic [IW-1:0] keep_wa;
  logic          keep_wd;
  logic          stk_we;
  logic          stk_re;
  logic          rd_en;
  logic          last_nx;
  logic [CW-1:0] sp_m1;
  logic [CW-1:0] ptr_p1;

  assign acc       = in_valid_i && in_ready_o;
  assign is_letter = (in_i.char_in >= ChA) && (in_i.char_in <= ChZ);
  assign is_open   = in_i.char_in == ChOpen;
  assign sp_m1     = sp_q - 1'b1;
  assign ptr_p1    = ptr_q + 1'b1;
  assign last_nx   = ptr_p1 == cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (acc && in_i.end_of_string) begin
          state_d = (sp_d != '0) ? ST_UNWIND : ST_DRAIN;
        end
      end
      ST_UNWIND: begin
        if (sp_q == '0 && !pop_vld_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (rd_en && last_nx) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath control
  always_comb begin
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    sp_d       = sp_q;
    ptr_d      = ptr_q;
    ovf_d      = ovf_q;
    pop_vld_d  = 1'b0;
    out_vld_d  = out_vld_q && !out_ready_i;
    byte_we    = 1'b0;
    keep_we    = 1'b0;
    keep_wa    = cnt_q[IW-1:0];
    keep_wd    = 1'b1;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    rd_en      = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        ptr_d      = '0;
        if (acc) begin
          if (cnt_q == LenC) begin
            ovf_d = 1'b1;
          end else begin
            byte_we = 1'b1;
            keep_we = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            if (is_letter) begin
              keep_wd = 1'b1;
            end else if (is_open) begin
              if (sp_q != LenC) begin
                stk_we = 1'b1;
                sp_d   = sp_q + 1'b1;
              end
            end else if (sp_q != '0) begin
              sp_d = sp_m1;
            end else begin
              keep_wd = 1'b0;
            end
          end
        end
      end
      ST_UNWIND: begin
        ptr_d   = '0;
        keep_we = pop_vld_q;
        keep_wa = stk_rd_q;
        keep_wd = 1'b0;
        if (sp_q != '0) begin
          stk_re    = 1'b1;
          sp_d      = sp_m1;
          pop_vld_d = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!out_vld_q || out_ready_i) begin
          rd_en     = 1'b1;
          out_vld_d = 1'b1;
          ptr_d     = ptr_p1;
          if (last_nx) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: begin
        ptr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      sp_q      <= '0;
      ptr_q     <= '0;
      ovf_q     <= 1'b0;
      pop_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sp_q      <= sp_d;
      ptr_q     <= ptr_d;
      ovf_q     <= ovf_d;
      pop_vld_q <= pop_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[cnt_q[IW-1:0]] <= in_i.char_in;
    end
    if (rd_en) begin
      byte_rd_q <= byte_mem[ptr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep_we) begin
      keep_mem[keep_wa] <= keep_wd;
    end
    if (rd_en) begin
      keep_rd_q <= keep_mem[ptr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[sp_q[IW-1:0]] <= cnt_q[IW-1:0];
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[sp_m1[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      last_q  <= last_nx;
      oflag_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_o.char_out = byte_rd_q;
  assign out_o.keep     = keep_rd_q;
  assign out_o.last_out = last_q;
  assign out_o.overflow = oflag_q;

`ifndef ASSERT_OFF
  a_sp_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= cnt_q)
    else $error("stack depth exceeds byte count");

  a_cnt_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LenC)
    else $error("byte count exceeds buffer size");

  a_drain_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> sp_q == '0 && !pop_vld_q)
    else $error("drain started with open entries on the stack");

  a_drain_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> ptr_q < cnt_q)
    else $error("drain pointer past stored bytes");
`endif

endmodule

// ===== verif/pbf_balance_checker.sv =====
// Checker for paren_balance_filter: tracks each string, predicts and compares results.
`timescale 1ns / 1ps

module pbf_balance_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pbf_pkg::pbf_in_t  in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pbf_pkg::pbf_out_t out_i,
  output int                fail_count_o,
  output int                pending_o
);
  import pbf_pkg::*;

  logic [7:0]  str_chars  [MaxLen];
  logic        str_keep   [MaxLen];
  logic [5:0]  open_stack [MaxLen];
  int unsigned open_depth = 0;
  int unsigned char_count = 0;
  logic        chars_dropped = 1'b0;
  int          mismatches = 0;
  pbf_out_t    filtered_q[$];

  task automatic take_char(input pbf_in_t item);
    pbf_out_t res;
    if (char_count >= MaxLen) begin
      chars_dropped = 1'b1;
    end else begin
      str_chars[char_count] = item.char_in;
      str_keep[char_count]  = 1'b1;
      if (item.char_in == ChOpen) begin
        open_stack[open_depth] = 6'(char_count);
        open_depth++;
      end else if (!(item.char_in >= ChA && item.char_in <= ChZ)) begin
        // anything else closes the latest open paren, or is dropped
        if (open_depth > 0) begin
          open_depth--;
        end else begin
          str_keep[char_count] = 1'b0;
        end
      end
      char_count++;
    end
    if (item.end_of_string) begin
      while (open_depth > 0) begin
        open_depth--;
        str_keep[open_stack[open_depth]] = 1'b0;
      end
      for (int k = 0; k < int'(char_count); k++) begin
        res.char_out = str_chars[k];
        res.keep     = str_keep[k];
        res.last_out = (k + 1 == int'(char_count));
        res.overflow = chars_dropped;
        filtered_q = {filtered_q, res};
      end
      char_count    = 0;
      open_depth    = 0;
      chars_dropped = 1'b0;
    end
  endtask

  task automatic check_result(input pbf_out_t got);
    pbf_out_t want;
    if (filtered_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("pbf check: unexpected item char=%h keep=%b last=%b ovf=%b",
                 got.char_out, got.keep, got.last_out, got.overflow);
      end
    end else begin
      want = filtered_q.pop_front();
      if (got.char_out !== want.char_out || got.keep !== want.keep ||
          got.last_out !== want.last_out || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display({"pbf check: expected char=%h keep=%b last=%b ovf=%b, ",
                    "got char=%h keep=%b last=%b ovf=%b"},
                   want.char_out, want.keep, want.last_out, want.overflow,
                   got.char_out, got.keep, got.last_out, got.overflow);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_depth    = 0;
      char_count    = 0;
      chars_dropped = 1'b0;
      mismatches    = 0;
      filtered_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_i);
      if (in_valid_i && in_ready_i) take_char(in_i);
    end
    fail_count_o = mismatches;
    pending_o    = filtered_q.size();
  end

endmodule

// ===== verif/tb_paren_balance_filter.sv =====
// Testbench top for paren_balance_filter: clock, reset, string stimulus, flow control, verdict.
`timescale 1ns / 1ps

module tb_paren_balance_filter;
  import pbf_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned LongHold    = 400;
  localparam logic [7:0]  ChClose     = 8'h29;

  localparam logic [8:0] DirectedItems [20] = '{
    {ChA, 1'b1}, {ChOpen, 1'b1}, {ChClose, 1'b1}, {8'h00, 1'b1},
    {ChOpen, 1'b0}, {ChZ, 1'b0}, {ChClose, 1'b1},
    {ChClose, 1'b0}, {ChOpen, 1'b0}, {ChOpen, 1'b0}, {ChA, 1'b0}, {8'hff, 1'b0},
    {ChClose, 1'b0}, {8'h60, 1'b0}, {8'h7b, 1'b0}, {8'h27, 1'b1},
    {ChOpen, 1'b0}, {ChOpen, 1'b0}, {ChClose, 1'b0}, {8'h62, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pbf_in_t     in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pbf_out_t    out_item;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 82;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  paren_balance_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  pbf_balance_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("paren_balance_filter: mismatch");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus one long hold on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item.char_in       = c;
    in_item.end_of_string = eos;
    in_valid              = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r = $urandom_range(99);
    if (r < 35) return ChOpen;
    if (r < 65) return ChClose;
    if (r < 85) return ChA + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_len();
    int r = $urandom_range(99);
    if (r < 85) return $urandom_range(10, 1);
    if (r < 93) return $urandom_range(MaxLen - 1, 11);
    return $urandom_range(MaxLen + 6, MaxLen);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned strings;
    int unsigned len;
    int          phase;
    sent    = 0;
    strings = 0;
    phase   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DirectedItems[i]) send_char(DirectedItems[i][8:1], DirectedItems[i][0]);

    while (sent < RandomItems) begin
      if (phase == 0 && sent >= RandomItems / 3) begin
        wait_drained();
        send_idle_pct = 82;
        recv_idle_pct = 18;
        phase = 1;
      end else if (phase == 1 && sent >= 2 * RandomItems / 3) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        phase = 2;
      end
      // make sure a full buffer and a dropped final byte both occur
      if (strings == 2) len = MaxLen;
      else if (strings == 5) len = MaxLen + 1;
      else len = pick_len();
      for (int unsigned i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
      sent += len;
      strings++;
    end

    wait_drained();
    repeat (2 * MaxLen + 8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("paren_balance_filter: match");
    end else begin
      $display("paren_balance_filter: mismatch");
    end
    $finish;
  end

endmodule
